// ----- hw/rtl/drt_pkg.sv -----
package drt_pkg;

  // Field widths
  localparam int unsigned CoordW = 16;
  localparam int unsigned SizeW  = 12;
  localparam int unsigned RotW   = 2;
  localparam int unsigned IdxW   = 2;

  // Configuration reset values
  localparam logic [SizeW-1:0] NativeWidthRst  = 12'd172;
  localparam logic [SizeW-1:0] NativeHeightRst = 12'd640;
  localparam logic [RotW-1:0]  RotationRst     = 2'd0;

  // Command codes
  typedef enum logic {
    CMD_MARK  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_NATIVE_WIDTH  = 2'd0,
    REG_NATIVE_HEIGHT = 2'd1,
    REG_ROTATION      = 2'd2
  } reg_idx_e;

  // Rotation codes
  typedef enum logic [RotW-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef struct packed {
    logic [SizeW-1:0] native_width;
    logic [SizeW-1:0] native_height;
    rot_e             rotation;
  } cfg_t;

  // Clipped half-open rectangle in logical coordinates
  typedef struct packed {
    logic             ok;
    logic [SizeW-1:0] left;
    logic [SizeW-1:0] top;
    logic [SizeW-1:0] right;
    logic [SizeW-1:0] bottom;
  } rect_t;

endpackage

// ----- hw/rtl/drt_clip.sv -----
module drt_clip (
  input  logic                                enable_i,
  input  logic signed [drt_pkg::CoordW-1:0]   x_i,
  input  logic signed [drt_pkg::CoordW-1:0]   y_i,
  input  logic signed [drt_pkg::CoordW-1:0]   w_i,
  input  logic signed [drt_pkg::CoordW-1:0]   h_i,
  input  logic        [drt_pkg::SizeW-1:0]    lim_w_i,
  input  logic        [drt_pkg::SizeW-1:0]    lim_h_i,
  output drt_pkg::rect_t                      rect_o
);
  import drt_pkg::*;

  logic signed [CoordW-1:0] xn, yn, wn, hn;
  logic signed [CoordW-1:0] l, t, r, b, rc, bc;
  logic signed [CoordW-1:0] lim_w, lim_h;
  logic                     size_ok, area_ok;

  always_comb begin
    // Negative size: move origin to the far edge, 16-bit wrap
    if (w_i[CoordW-1]) begin
      xn = x_i + w_i + CoordW'(1);
      wn = -w_i;
    end else begin
      xn = x_i;
      wn = w_i;
    end
    if (h_i[CoordW-1]) begin
      yn = y_i + h_i + CoordW'(1);
      hn = -h_i;
    end else begin
      yn = y_i;
      hn = h_i;
    end
    // -32768 negates to itself and stays invalid
    size_ok = (wn > 0) && (hn > 0);

    l = xn[CoordW-1] ? '0 : xn;
    t = yn[CoordW-1] ? '0 : yn;
    r = xn + wn;
    b = yn + hn;

    lim_w = $signed({{(CoordW-SizeW){1'b0}}, lim_w_i});
    lim_h = $signed({{(CoordW-SizeW){1'b0}}, lim_h_i});
    rc = (r > lim_w) ? lim_w : r;
    bc = (b > lim_h) ? lim_h : b;

    area_ok = (l < rc) && (t < bc);

    rect_o.ok     = enable_i && size_ok && area_ok;
    rect_o.left   = l[SizeW-1:0];
    rect_o.top    = t[SizeW-1:0];
    rect_o.right  = rc[SizeW-1:0];
    rect_o.bottom = bc[SizeW-1:0];
  end

endmodule

// ----- hw/rtl/drt_box.sv -----
module drt_box (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         flush_i,
  input  drt_pkg::rect_t               rect_i,
  input  drt_pkg::cfg_t                cfg_i,
  output logic [drt_pkg::SizeW-1:0]    rows_o
);
  import drt_pkg::*;

  logic             valid_q, valid_d;
  logic [SizeW-1:0] left_q, top_q, right_q, bottom_q;
  logic [SizeW-1:0] left_d, top_d, right_d, bottom_d;
  logic             mvalid;
  logic signed [SizeW:0] diff;

  // Merge the clipped rectangle into the box
  always_comb begin
    mvalid   = valid_q || rect_i.ok;
    left_d   = left_q;
    top_d    = top_q;
    right_d  = right_q;
    bottom_d = bottom_q;
    if (rect_i.ok) begin
      if (!valid_q) begin
        left_d   = rect_i.left;
        top_d    = rect_i.top;
        right_d  = rect_i.right;
        bottom_d = rect_i.bottom;
      end else begin
        if (rect_i.left   < left_q)   left_d   = rect_i.left;
        if (rect_i.top    < top_q)    top_d    = rect_i.top;
        if (rect_i.right  > right_q)  right_d  = rect_i.right;
        if (rect_i.bottom > bottom_q) bottom_d = rect_i.bottom;
      end
    end
    valid_d = flush_i ? 1'b0 : mvalid;
  end

  // Native row count from the merged box
  always_comb begin
    diff = '0;
    unique case (cfg_i.rotation)
      ROT_0:   diff = $signed({1'b0, bottom_d});
      ROT_90:  diff = $signed({1'b0, right_d});
      ROT_180: diff = $signed({1'b0, cfg_i.native_height}) - $signed({1'b0, top_d});
      ROT_270: diff = $signed({1'b0, cfg_i.native_height}) - $signed({1'b0, left_d});
      default: diff = '0;
    endcase
    if (!mvalid || diff[SizeW]) begin
      rows_o = '0;
    end else begin
      rows_o = diff[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      left_q   <= left_d;
      top_q    <= top_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
    end
  end

endmodule

// ----- hw/rtl/dirty_region_tracker_unit.sv -----
// Dirty region tracker: bounding box of marked rectangles on a rotated panel.
// A flush result becomes valid when loaded from input to output register.
// Throughput: one transaction per cycle; input register, clip/merge logic and
//   output register. A stalled result holds a flush in the input register.
// Reset (async, active low): box empty, native size 172 x 640, rotation 0,
//   both pipeline stages empty.
module dirty_region_tracker_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [drt_pkg::IdxW-1:0]           cfg_idx_i,
  input  logic [drt_pkg::SizeW-1:0]          cfg_data_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic signed [drt_pkg::CoordW-1:0]  rect_x_i,
  input  logic signed [drt_pkg::CoordW-1:0]  rect_y_i,
  input  logic signed [drt_pkg::CoordW-1:0]  rect_w_i,
  input  logic signed [drt_pkg::CoordW-1:0]  rect_h_i,
  input  logic                               force_all_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [drt_pkg::SizeW-1:0]          send_rows_o,
  output logic                               send_valid_o
);
  import drt_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NATIVE_WIDTH:  cfg_d.native_width  = cfg_data_i;
        REG_NATIVE_HEIGHT: cfg_d.native_height = cfg_data_i;
        REG_ROTATION:      cfg_d.rotation      = rot_e'(cfg_data_i[RotW-1:0]);
        default:           cfg_d = cfg_q;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.native_width  <= NativeWidthRst;
      cfg_q.native_height <= NativeHeightRst;
      cfg_q.rotation      <= rot_e'(RotationRst);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------
  logic                     s1_valid_q;
  cmd_e                     s1_cmd_q;
  logic signed [CoordW-1:0] s1_x_q, s1_y_q, s1_w_q, s1_h_q;
  logic                     s1_force_q;
  logic                     s1_flush;
  logic                     step;
  logic                     in_accept;

  // Only a flush needs the output slot; marks always drain.
  assign s1_flush   = (s1_cmd_q == CMD_FLUSH);
  assign in_stall_o = s1_valid_q && s1_flush && out_valid_o && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign step       = s1_valid_q && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q   <= cmd_e'(cmd_i);
      s1_x_q     <= rect_x_i;
      s1_y_q     <= rect_y_i;
      s1_w_q     <= rect_w_i;
      s1_h_q     <= rect_h_i;
      s1_force_q <= force_all_i;
    end
  end

  // ---------------------------------------------------------------
  // Clip: a mark uses its own rectangle, a forced flush marks the
  // whole logical screen through the same path, a plain flush adds none.
  // ---------------------------------------------------------------
  logic [SizeW-1:0]         lw, lh;
  logic signed [CoordW-1:0] cx, cy, cw, ch;
  logic                     clip_en;
  rect_t                    rect;

  assign lw = cfg_q.rotation[0] ? cfg_q.native_height : cfg_q.native_width;
  assign lh = cfg_q.rotation[0] ? cfg_q.native_width  : cfg_q.native_height;

  always_comb begin
    if (s1_flush) begin
      cx      = '0;
      cy      = '0;
      cw      = $signed({{(CoordW-SizeW){1'b0}}, lw});
      ch      = $signed({{(CoordW-SizeW){1'b0}}, lh});
      clip_en = s1_force_q;
    end else begin
      cx      = s1_x_q;
      cy      = s1_y_q;
      cw      = s1_w_q;
      ch      = s1_h_q;
      clip_en = 1'b1;
    end
  end

  drt_clip u_clip (
    .enable_i (clip_en),
    .x_i      (cx),
    .y_i      (cy),
    .w_i      (cw),
    .h_i      (ch),
    .lim_w_i  (lw),
    .lim_h_i  (lh),
    .rect_o   (rect)
  );

  // ---------------------------------------------------------------
  // Box state, merge and row count
  // ---------------------------------------------------------------
  logic [SizeW-1:0] rows;

  drt_box u_box (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .flush_i (s1_flush),
    .rect_i  (rect),
    .cfg_i   (cfg_q),
    .rows_o  (rows)
  );

  // ---------------------------------------------------------------
  // Output register: loaded by a flush, held while stalled
  // ---------------------------------------------------------------
  logic             out_valid_q, out_valid_d;
  logic [SizeW-1:0] rows_q;

  always_comb begin
    if (step && s1_flush) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_flush) begin
      rows_q <= rows;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign send_rows_o  = rows_q;
  assign send_valid_o = (rows_q != '0);

endmodule
